// File: hdl/dcs_pkg.sv
// Shared types and constants for the deferred commit scheduler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package dcs_pkg;

  // Reset values of the delay registers, in frame ticks
  localparam logic [15:0] CHECKPOINT_RESET = 16'(30 * 60);
  localparam logic [15:0] RETRY_RESET      = 16'(30 * 10);
  localparam logic [15:0] TIMEOUT_RESET    = 16'(30 * 15);
  localparam logic [31:0] TIMEOUT_ERROR    = 32'hffff_ffff;
  localparam logic [15:0] WAIT_MAX         = 16'hffff;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STORAGE_PRESENT  = 3'd0,
    REG_STORAGE_WRITABLE = 3'd1,
    REG_START_SEQUENCE   = 3'd2,
    REG_CHECKPOINT_DELAY = 3'd3,
    REG_RETRY_DELAY      = 3'd4,
    REG_ACK_TIMEOUT      = 3'd5
  } reg_index_t;

  // Input op codes
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_CHECKPOINT = 2'd1,
    OP_RESET      = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  // Classified kind of a transaction
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_CHECKPOINT,
    KIND_RESET,
    KIND_NONE
  } kind_t;

  // Command carried from the front to the back
  typedef struct packed {
    kind_t       kind;
    logic        change;
    logic        urgent;
    logic [31:0] ack_sequence;
    logic [31:0] ack_status;
  } cmd_t;

  // Configuration register file; start_sequence only reloads the issued number
  typedef struct packed {
    logic        storage_present;
    logic        storage_writable;
    logic [15:0] checkpoint_delay;
    logic [15:0] retry_delay;
    logic [15:0] ack_timeout;
  } cfg_t;

  // Scheduler state
  typedef struct packed {
    logic [31:0] issued_sequence;
    logic [15:0] wait_count;
    logic [15:0] defer_count;
    logic [31:0] error_word;
    logic        pending;
    logic        dirty;
    logic        urgent;
    logic        reset_commit;
    logic [1:0]  reset_writes_left;
  } sched_t;

endpackage

// File: hdl/dcs_front.sv
// Front stage: accepts input transactions and classifies the op code.
// Depends on dcs_pkg; feeds dcs_queue.
`timescale 1ns / 1ps

module dcs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    op,
  input  logic          change_seen,
  input  logic          urgent_change,
  input  logic [31:0]   ack_sequence,
  input  logic [31:0]   ack_status,
  output logic          push,
  output dcs_pkg::cmd_t push_cmd,
  input  logic          queue_full
);

  logic          front_valid;
  dcs_pkg::cmd_t front_cmd;
  dcs_pkg::cmd_t decoded;
  logic          take;

  // Classify the incoming op
  always_comb begin
    decoded.change       = change_seen;
    decoded.urgent       = urgent_change;
    decoded.ack_sequence = ack_sequence;
    decoded.ack_status   = ack_status;
    case (dcs_pkg::op_t'(op))
      dcs_pkg::OP_TICK:       decoded.kind = dcs_pkg::KIND_TICK;
      dcs_pkg::OP_CHECKPOINT: decoded.kind = dcs_pkg::KIND_CHECKPOINT;
      dcs_pkg::OP_RESET:      decoded.kind = dcs_pkg::KIND_RESET;
      default:                decoded.kind = dcs_pkg::KIND_NONE;
    endcase
  end

  // Hold the stage while the queue is full
  assign in_stall = front_valid && queue_full;
  assign take     = in_valid && !in_stall;
  assign push     = front_valid && !queue_full;
  assign push_cmd = front_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (take) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      front_cmd <= decoded;
    end
  end

endmodule

// File: hdl/dcs_queue.sv
// Short command queue decoupling the front stage from the back stage.
// Depends on dcs_pkg.
`timescale 1ns / 1ps

module dcs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dcs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output dcs_pkg::cmd_t head_cmd
);

  dcs_pkg::cmd_t                      entries [dcs_pkg::QUEUE_DEPTH];
  logic [dcs_pkg::QUEUE_PTR_W-1:0]    wr_ptr;
  logic [dcs_pkg::QUEUE_PTR_W-1:0]    rd_ptr;
  logic [dcs_pkg::QUEUE_CNT_W-1:0]    count;
  logic                               do_push;
  logic                               do_pop;

  assign full       = (count == dcs_pkg::QUEUE_CNT_W'(dcs_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == dcs_pkg::QUEUE_PTR_W'(dcs_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == dcs_pkg::QUEUE_PTR_W'(dcs_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: hdl/dcs_back.sv
// Back stage: configuration registers, scheduler state update and the
// registered result. Depends on dcs_pkg; fed by dcs_queue.
`timescale 1ns / 1ps

module dcs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          head_valid,
  input  dcs_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          save_started,
  output logic [31:0]   save_sequence,
  output logic          change_absorbed,
  output logic          request_pending,
  output logic          unsaved,
  output logic [31:0]   last_error
);

  dcs_pkg::cfg_t   cfg;
  dcs_pkg::sched_t sched;
  dcs_pkg::sched_t sched_next;
  logic            started_next;
  logic            absorbed_next;

  // Take a command whenever the result register is free or draining
  assign pop = head_valid && (!out_valid || !out_stall);

  // Apply one command to the scheduler state
  always_comb begin
    logic [15:0] wait_inc;
    logic [1:0]  left_dec;
    sched_next    = sched;
    started_next  = 1'b0;
    absorbed_next = 1'b0;
    wait_inc      = '0;
    left_dec      = '0;

    // Match the acknowledge on a tick
    if (head_cmd.kind == dcs_pkg::KIND_TICK && sched.pending) begin
      if (head_cmd.ack_sequence == sched.issued_sequence) begin
        sched_next.pending    = 1'b0;
        sched_next.error_word = head_cmd.ack_status;
        sched_next.wait_count = '0;
        if (head_cmd.ack_status != '0) begin
          sched_next.dirty       = 1'b1;
          sched_next.defer_count = cfg.retry_delay;
        end else if (sched.reset_commit && sched.reset_writes_left != '0) begin
          left_dec = sched.reset_writes_left - 1'b1;
          sched_next.reset_writes_left = left_dec;
          if (left_dec != '0) begin
            sched_next.dirty       = 1'b1;
            sched_next.urgent      = 1'b1;
            sched_next.defer_count = '0;
          end
        end
        sched_next.reset_commit = 1'b0;
      end else begin
        wait_inc = (sched.wait_count != dcs_pkg::WAIT_MAX) ?
                   sched.wait_count + 1'b1 : sched.wait_count;
        sched_next.wait_count = wait_inc;
        if (wait_inc > cfg.ack_timeout) begin
          sched_next.error_word = dcs_pkg::TIMEOUT_ERROR;
        end
      end
    end

    // Absorb the change flags
    if (head_cmd.kind != dcs_pkg::KIND_NONE && head_cmd.change) begin
      absorbed_next = 1'b1;
      if (!sched_next.dirty) begin
        sched_next.defer_count = cfg.checkpoint_delay;
      end
      sched_next.dirty = 1'b1;
      if (head_cmd.urgent) begin
        sched_next.urgent      = 1'b1;
        sched_next.defer_count = '0;
      end
    end

    case (head_cmd.kind)
      dcs_pkg::KIND_TICK: begin
        // Count the deferral down or issue a request
        if (cfg.storage_present && cfg.storage_writable &&
            !sched_next.pending && sched_next.dirty) begin
          if (!sched_next.urgent && sched_next.defer_count != '0) begin
            sched_next.defer_count = sched_next.defer_count - 1'b1;
          end else begin
            sched_next.issued_sequence = sched_next.issued_sequence + 1'b1;
            sched_next.pending         = 1'b1;
            sched_next.reset_commit    = (sched_next.reset_writes_left != '0);
            sched_next.dirty           = 1'b0;
            sched_next.urgent          = 1'b0;
            sched_next.wait_count      = '0;
            sched_next.error_word      = '0;
            started_next               = 1'b1;
          end
        end
      end
      dcs_pkg::KIND_CHECKPOINT: begin
        if (sched_next.dirty) begin
          sched_next.urgent      = 1'b1;
          sched_next.defer_count = '0;
        end
      end
      dcs_pkg::KIND_RESET: begin
        sched_next.urgent            = 1'b1;
        sched_next.defer_count       = '0;
        sched_next.reset_writes_left = 2'd2;
        sched_next.reset_commit      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.storage_present  <= 1'b0;
      cfg.storage_writable <= 1'b0;
      cfg.checkpoint_delay <= dcs_pkg::CHECKPOINT_RESET;
      cfg.retry_delay      <= dcs_pkg::RETRY_RESET;
      cfg.ack_timeout      <= dcs_pkg::TIMEOUT_RESET;
      sched                <= '0;
    end else if (cfg_write) begin
      case (dcs_pkg::reg_index_t'(cfg_index))
        dcs_pkg::REG_STORAGE_PRESENT:  cfg.storage_present  <= cfg_data[0];
        dcs_pkg::REG_STORAGE_WRITABLE: cfg.storage_writable <= cfg_data[0];
        dcs_pkg::REG_START_SEQUENCE: begin
          sched.issued_sequence <= cfg_data;
        end
        dcs_pkg::REG_CHECKPOINT_DELAY: cfg.checkpoint_delay <= cfg_data[15:0];
        dcs_pkg::REG_RETRY_DELAY:      cfg.retry_delay      <= cfg_data[15:0];
        dcs_pkg::REG_ACK_TIMEOUT:      cfg.ack_timeout      <= cfg_data[15:0];
        default: begin
        end
      endcase
    end else if (pop) begin
      sched <= sched_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      save_started    <= started_next;
      save_sequence   <= sched_next.issued_sequence;
      change_absorbed <= absorbed_next;
      request_pending <= sched_next.pending;
      unsaved         <= sched_next.dirty || sched_next.pending;
      last_error      <= sched_next.error_word;
    end
  end

endmodule

// File: hdl/deferred_commit_scheduler.sv
// Top level of the deferred commit scheduler.
// Depends on dcs_pkg, dcs_front, dcs_queue and dcs_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event per transaction:
//   op (tick, checkpoint, reset of progress), change flags and the latest
//   acknowledge number and status from the storage partner. The output
//   channel (out_valid / out_stall) returns exactly one result per event,
//   in order: whether a commit request was issued, its sequence number,
//   whether the change flags were absorbed, pending / unsaved flags and
//   the last partner status (all ones on acknowledge timeout).
//   An event is registered in the classify stage, then in the two-entry
//   command queue, then in the result register, which holds it until
//   taken. Throughput is one event per cycle while the output channel
//   does not stall; the state update in the back stage is combinational.
//   When the receiver stalls, the result register holds, the queue fills
//   and the front stage then raises in_stall; nothing is dropped.
//   Reset clears the front stage, the queue, the scheduler state and
//   out_valid, and loads the default configuration. Configuration is
//   written through cfg_write / cfg_index / cfg_data while no event is in
//   flight; writing start_sequence also reloads the issued sequence number.
`timescale 1ns / 1ps

module deferred_commit_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic        change_seen,
  input  logic        urgent_change,
  input  logic [31:0] ack_sequence,
  input  logic [31:0] ack_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        save_started,
  output logic [31:0] save_sequence,
  output logic        change_absorbed,
  output logic        request_pending,
  output logic        unsaved,
  output logic [31:0] last_error
);

  logic          push;
  dcs_pkg::cmd_t push_cmd;
  logic          queue_full;
  logic          pop;
  logic          head_valid;
  dcs_pkg::cmd_t head_cmd;

  dcs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .change_seen   (change_seen),
    .urgent_change (urgent_change),
    .ack_sequence  (ack_sequence),
    .ack_status    (ack_status),
    .push          (push),
    .push_cmd      (push_cmd),
    .queue_full    (queue_full)
  );

  dcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  dcs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .save_started    (save_started),
    .save_sequence   (save_sequence),
    .change_absorbed (change_absorbed),
    .request_pending (request_pending),
    .unsaved         (unsaved),
    .last_error      (last_error)
  );

endmodule

// File: verif/tb_deferred_commit_scheduler.sv
// Self-checking testbench for deferred_commit_scheduler: directed and random event
// streams under random idling on both channels, predicted by a scoreboard class.
// Depends on dcs_pkg and the deferred_commit_scheduler RTL.
`timescale 1ns / 1ps

module tb_deferred_commit_scheduler;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int END_WAIT = 8;
  localparam int PHASE_EVENTS = 240;
  localparam int HOLD_TICKS = 40;
  // Indexes past the register list, expected to be ignored
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // How the acknowledge number of an event is picked
  typedef enum {ACK_ISSUED, ACK_PREVIOUS, ACK_MISS, ACK_FIXED} ack_pick_t;

  typedef struct packed {
    logic        started;
    logic [31:0] seq_no;
    logic        absorbed;
    logic        pending;
    logic        unsaved;
    logic [31:0] err;
  } commit_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = '0;
  logic        change_seen = 1'b0;
  logic        urgent_change = 1'b0;
  logic [31:0] ack_sequence = '0;
  logic [31:0] ack_status = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        save_started;
  logic [31:0] save_sequence;
  logic        change_absorbed;
  logic        request_pending;
  logic        unsaved;
  logic [31:0] last_error;

  bit quiet = 1'b0;
  int cycle_count = 0;

  deferred_commit_scheduler dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .change_seen(change_seen),
    .urgent_change(urgent_change),
    .ack_sequence(ack_sequence),
    .ack_status(ack_status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .save_started(save_started),
    .save_sequence(save_sequence),
    .change_absorbed(change_absorbed),
    .request_pending(request_pending),
    .unsaved(unsaved),
    .last_error(last_error)
  );

  // Commit schedule predictor and result checker
  class commit_scoreboard;
    bit          present;
    bit          writable;
    logic [15:0] ckpt_delay;
    logic [15:0] retry_gap;
    logic [15:0] ack_limit;
    logic [31:0] issued;
    logic [15:0] wait_cnt;
    logic [15:0] defer_cnt;
    logic [31:0] err_word;
    bit          pending;
    bit          dirty;
    bit          urgent;
    bit          reset_commit;
    logic [1:0]  writes_left;
    commit_status_t awaited_status[$];
    int failures;

    function new();
      present = 1'b0;
      writable = 1'b0;
      ckpt_delay = dcs_pkg::CHECKPOINT_RESET;
      retry_gap = dcs_pkg::RETRY_RESET;
      ack_limit = dcs_pkg::TIMEOUT_RESET;
      issued = '0;
      wait_cnt = '0;
      defer_cnt = '0;
      err_word = '0;
      pending = 1'b0;
      dirty = 1'b0;
      urgent = 1'b0;
      reset_commit = 1'b0;
      writes_left = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (dcs_pkg::reg_index_t'(idx))
        dcs_pkg::REG_STORAGE_PRESENT:  present = val[0];
        dcs_pkg::REG_STORAGE_WRITABLE: writable = val[0];
        dcs_pkg::REG_START_SEQUENCE:   issued = val;
        dcs_pkg::REG_CHECKPOINT_DELAY: ckpt_delay = val[15:0];
        dcs_pkg::REG_RETRY_DELAY:      retry_gap = val[15:0];
        dcs_pkg::REG_ACK_TIMEOUT:      ack_limit = val[15:0];
        default: ;
      endcase
    endfunction

    // Take a change flag: a fresh change starts the deferral, urgent clears it
    function bit absorb(bit chg, bit urg);
      if (!chg) return 1'b0;
      if (!dirty) defer_cnt = ckpt_delay;
      dirty = 1'b1;
      if (urg) begin
        urgent = 1'b1;
        defer_cnt = '0;
      end
      return 1'b1;
    endfunction

    function void note_event(dcs_pkg::op_t o, bit chg, bit urg, logic [31:0] ack,
                             logic [31:0] st);
      commit_status_t r;
      r = '0;
      case (o)
        dcs_pkg::OP_TICK: begin
          // Match the acknowledge against the outstanding request
          if (pending) begin
            if (ack == issued) begin
              pending = 1'b0;
              err_word = st;
              wait_cnt = '0;
              if (st != '0) begin
                dirty = 1'b1;
                defer_cnt = retry_gap;
              end else if (reset_commit && writes_left != '0) begin
                writes_left = writes_left - 2'd1;
                if (writes_left != '0) begin
                  dirty = 1'b1;
                  urgent = 1'b1;
                  defer_cnt = '0;
                end
              end
              reset_commit = 1'b0;
            end else begin
              if (wait_cnt != dcs_pkg::WAIT_MAX) wait_cnt = wait_cnt + 16'd1;
              if (wait_cnt > ack_limit) err_word = dcs_pkg::TIMEOUT_ERROR;
            end
          end
          r.absorbed = absorb(chg, urg);
          // Count the deferral down or issue a new request
          if (present && writable && !pending && dirty) begin
            if (!urgent && defer_cnt != '0) begin
              defer_cnt = defer_cnt - 16'd1;
            end else begin
              issued = issued + 32'd1;
              pending = 1'b1;
              reset_commit = (writes_left != '0);
              dirty = 1'b0;
              urgent = 1'b0;
              wait_cnt = '0;
              err_word = '0;
              r.started = 1'b1;
            end
          end
        end
        dcs_pkg::OP_CHECKPOINT: begin
          r.absorbed = absorb(chg, urg);
          if (dirty) begin
            urgent = 1'b1;
            defer_cnt = '0;
          end
        end
        dcs_pkg::OP_RESET: begin
          r.absorbed = absorb(chg, urg);
          urgent = 1'b1;
          defer_cnt = '0;
          writes_left = 2'd2;
          reset_commit = 1'b0;
        end
        default: ;
      endcase
      r.seq_no = issued;
      r.pending = pending;
      r.unsaved = dirty || pending;
      r.err = err_word;
      awaited_status.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        failures++;
        if (failures <= 100)
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
      end
    endfunction

    function void check_result(commit_status_t got);
      commit_status_t exp;
      if (awaited_status.size() == 0) begin
        failures++;
        if (failures <= 100)
          $display("%0t: unexpected result, expected none actual %p", $time, got);
        return;
      end
      exp = awaited_status.pop_front();
      compare_field("save_started", 32'(exp.started), 32'(got.started));
      compare_field("save_sequence", exp.seq_no, got.seq_no);
      compare_field("change_absorbed", 32'(exp.absorbed), 32'(got.absorbed));
      compare_field("request_pending", 32'(exp.pending), 32'(got.pending));
      compare_field("unsaved", 32'(exp.unsaved), 32'(got.unsaved));
      compare_field("last_error", exp.err, got.err);
    endfunction
  endclass

  commit_scoreboard sb = new();

  always #5 clk = ~clk;

  // Record accepted events and check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_event(dcs_pkg::op_t'(op), change_seen, urgent_change, ack_sequence,
                      ack_status);
      if (out_valid && !out_stall)
        sb.check_result('{save_started, save_sequence, change_absorbed, request_pending,
                          unsaved, last_error});
    end
  end

  // Stall the result channel at random outside quiet stretches
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 29);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one event, then hold it until the transaction is taken
  task automatic drive_event(dcs_pkg::op_t o, bit chg, bit urg, ack_pick_t pick,
                             logic [31:0] ack_val, logic [31:0] st);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    change_seen <= chg;
    urgent_change <= urg;
    ack_status <= st;
    case (pick)
      ACK_ISSUED:   ack_sequence <= sb.issued;
      ACK_PREVIOUS: ack_sequence <= sb.issued - 32'd1;
      ACK_MISS:     ack_sequence <= sb.issued + 32'd1;
      default:      ack_sequence <= ack_val;
    endcase
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drive_random_event();
    int roll;
    dcs_pkg::op_t o;
    ack_pick_t pick;
    logic [31:0] st;
    roll = $urandom_range(99);
    if (roll < 70) o = dcs_pkg::OP_TICK;
    else if (roll < 82) o = dcs_pkg::OP_CHECKPOINT;
    else if (roll < 92) o = dcs_pkg::OP_RESET;
    else o = dcs_pkg::OP_UNUSED;
    roll = $urandom_range(99);
    if (roll < 55) pick = ACK_ISSUED;
    else if (roll < 65) pick = ACK_PREVIOUS;
    else if (roll < 75) pick = ACK_MISS;
    else pick = ACK_FIXED;
    roll = $urandom_range(99);
    if (roll < 70) st = '0;
    else if (roll < 90) st = $urandom;
    else st = dcs_pkg::TIMEOUT_ERROR;
    drive_event(o, $urandom_range(99) < 40, $urandom_range(3) == 0, pick, $urandom, st);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic configure(bit pres, bit wr, logic [31:0] start, logic [15:0] ckpt,
                           logic [15:0] retry, logic [15:0] tmo);
    write_reg(dcs_pkg::REG_STORAGE_PRESENT, {31'd0, pres});
    write_reg(dcs_pkg::REG_STORAGE_WRITABLE, {31'd0, wr});
    write_reg(dcs_pkg::REG_START_SEQUENCE, start);
    write_reg(dcs_pkg::REG_CHECKPOINT_DELAY, {16'd0, ckpt});
    write_reg(dcs_pkg::REG_RETRY_DELAY, {16'd0, retry});
    write_reg(dcs_pkg::REG_ACK_TIMEOUT, {16'd0, tmo});
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: no store, so nothing commits
    drive_event(dcs_pkg::OP_UNUSED, 1'b1, 1'b1, ACK_FIXED, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_TICK, 1'b1, 1'b0, ACK_FIXED, 32'hffff_ffff, 32'hffff_ffff);
    drive_event(dcs_pkg::OP_CHECKPOINT, 1'b0, 1'b0, ACK_FIXED, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_RESET, 1'b0, 1'b0, ACK_FIXED, 32'h0, 32'h0);
    settle();

    // Start just below the wrap point; spare indexes must be ignored
    configure(1'b1, 1'b1, 32'hffff_ffff, 16'd2, 16'd1, 16'd2);
    write_reg(REG_SPARE_LO, 32'hffff_ffff);
    write_reg(REG_SPARE_HI, 32'hffff_ffff);
    drive_event(dcs_pkg::OP_TICK, 1'b1, 1'b0, ACK_MISS, 32'h0, 32'h0);
    // Let the acknowledge time out
    repeat (4) drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_MISS, 32'h0, 32'h0);
    // Fail the commit, then retry and succeed
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_ISSUED, 32'h0, 32'h5);
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_MISS, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_MISS, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_ISSUED, 32'h0, 32'h0);
    // Reset without change, then the forced pair of commits
    drive_event(dcs_pkg::OP_RESET, 1'b0, 1'b0, ACK_MISS, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_MISS, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_TICK, 1'b1, 1'b0, ACK_MISS, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_ISSUED, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_MISS, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_ISSUED, 32'h0, 32'h0);
    // Checkpoint promotes an ordinary change
    drive_event(dcs_pkg::OP_CHECKPOINT, 1'b1, 1'b0, ACK_MISS, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_MISS, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_ISSUED, 32'h0, 32'hffff_ffff);
    drive_event(dcs_pkg::OP_TICK, 1'b1, 1'b1, ACK_FIXED, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_FIXED, 32'hffff_ffff, 32'hffff_ffff);

    // Random phases, one register setting each
    for (int k = 0; k < 7; k++) begin
      settle();
      quiet = (k == 5);
      case (k)
        0: configure(1'b1, 1'b1, 32'h0, 16'd0, 16'd0, 16'd0);
        1: configure(1'b1, 1'b1, $urandom, 16'($urandom_range(1, 6)),
                     16'($urandom_range(0, 4)), 16'($urandom_range(1, 8)));
        2: configure(1'b0, 1'b1, $urandom, 16'($urandom_range(0, 6)),
                     16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)));
        3: configure(1'b1, 1'b0, $urandom, 16'($urandom_range(0, 6)),
                     16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)));
        4: configure(1'b1, 1'b1, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hfffe);
        5: configure(1'b1, 1'b1, 32'hffff_fff0, 16'($urandom_range(0, 4)),
                     16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)));
        default: configure(1'b1, 1'b1, $urandom, 16'($urandom_range(0, 20)),
                           16'($urandom_range(0, 20)), 16'($urandom_range(0, 30)));
      endcase
      repeat (PHASE_EVENTS) drive_random_event();
    end

    // Hold a request unacknowledged under the largest timeout, then tighten it
    settle();
    quiet = 1'b1;
    configure(1'b1, 1'b1, 32'h8000_0000, 16'd0, 16'd0, 16'hffff);
    drive_event(dcs_pkg::OP_TICK, 1'b1, 1'b1, ACK_MISS, 32'h0, 32'h0);
    repeat (HOLD_TICKS) drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_MISS, 32'h0, 32'h0);
    settle();
    write_reg(dcs_pkg::REG_ACK_TIMEOUT, 32'h0000_0010);
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_MISS, 32'h0, 32'h0);
    drive_event(dcs_pkg::OP_TICK, 1'b0, 1'b0, ACK_ISSUED, 32'h0, 32'h0);
    quiet = 1'b0;

    settle();
    repeat (END_WAIT) @(posedge clk);
    if (sb.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
hdl/dcs_pkg.sv
hdl/dcs_front.sv
hdl/dcs_queue.sv
hdl/dcs_back.sv
hdl/deferred_commit_scheduler.sv
verif/tb_deferred_commit_scheduler.sv
